[sv/list_mode_event_deframer_top_defines.svh]
// Assertion macros for the list-mode event deframer.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef LIST_MODE_EVENT_DEFRAMER_TOP_DEFINES_SVH
`define LIST_MODE_EVENT_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define LMED_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LMED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lmed_pkg.sv]
// Shared types, codes and helpers for the list-mode event deframer.
// No dependencies.
package lmed_pkg;

    localparam int HIST_BINS_DEF = 1024;
    localparam int STAT_NUM      = 7;

    // request op codes
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_HIST = 2'd1;
    localparam logic [1:0] OP_STAT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_SPILL = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // statistic counter numbers
    localparam logic [2:0] STAT_OOO    = 3'd0;
    localparam logic [2:0] STAT_OOR    = 3'd1;
    localparam logic [2:0] STAT_PILEUP = 3'd2;
    localparam logic [2:0] STAT_SAT    = 3'd3;
    localparam logic [2:0] STAT_VIRT   = 3'd4;
    localparam logic [2:0] STAT_TRACE  = 3'd5;
    localparam logic [2:0] STAT_SPILL  = 3'd6;

    // event status bits
    localparam logic [15:0] ST_SUM    = 16'h000A;
    localparam logic [15:0] ST_QDC    = 16'h000C;
    localparam logic [15:0] ST_PILEUP = 16'h0010;
    localparam logic [15:0] ST_TRACE  = 16'h0020;
    localparam logic [15:0] ST_SAT    = 16'h0040;
    localparam logic [15:0] ST_VIRT   = 16'h0080;

    localparam logic [15:0] SUM_WORDS = 16'd4;
    localparam logic [15:0] QDC_WORDS = 16'd8;

    // spill marker words
    localparam logic [31:0] MARK_S = 32'h0000_0053;
    localparam logic [31:0] MARK_P = 32'h0000_0050;
    localparam logic [31:0] MARK_I = 32'h0000_0049;
    localparam logic [31:0] MARK_L = 32'h0000_004C;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] word;
        logic [9:0]  index;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] timestamp;
        logic [15:0] channel_id;
        logic [15:0] event_status;
        logic [15:0] energy;
        logic [15:0] trace_length;
        logic [31:0] spill_number;
        logic [31:0] wall_clock;
        logic        out_of_order;
        logic        id_out_of_range;
        logic [31:0] value;
    } result_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

[sv/list_mode_event_deframer_top.sv]
// List-mode event deframer: parser, statistic counters and histogram.
// Depends on lmed_pkg and list_mode_event_deframer_top_defines.svh.
// Path: the request reg feeds the parser, then the histogram read reg, then the output
// reg. Throughput: one request per cycle unless results back up or the clear runs.
// Reset: parser state and counters clear at once; then a clearing pass zeroes the
// histogram memory, one bin a cycle, with item_ready held low.
`include "list_mode_event_deframer_top_defines.svh"

module list_mode_event_deframer_top #(
    parameter int HIST_BINS = lmed_pkg::HIST_BINS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  lmed_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output lmed_pkg::result_t result
);

    localparam int HIST_AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

    // parser phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SPILL  = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    // ------------------------------------------------------------------
    // Pipeline control: each stage moves when it is empty or its
    // successor moves, so bubbles fill and a held result does not stall
    // the input until the whole pipe is full.
    // ------------------------------------------------------------------
    logic clr_reg;
    logic [HIST_AW-1:0] clr_cnt_reg;

    logic            s1_valid_reg;
    lmed_pkg::item_t s1_item_reg;

    logic              s2_valid_reg;
    lmed_pkg::result_t s2_res_reg;
    logic              s2_hist_rd_reg;   // value comes from histogram
    logic              s2_inc_reg;       // bump histogram bin
    logic [HIST_AW-1:0] s2_addr_reg;
    logic              s2_fwd_reg;       // bypass a write done on entry
    logic [31:0]       s2_fwd_data_reg;

    logic              result_valid_reg;
    lmed_pkg::result_t result_reg;

    logic out_adv, s2_adv, s1_adv, s1_go;

    assign out_adv    = !result_valid_reg || result_ready;
    assign s2_adv     = !s2_valid_reg || out_adv;
    assign s1_adv     = !s1_valid_reg || s2_adv;
    assign s1_go      = s1_valid_reg && s1_adv;
    assign item_ready = s1_adv && !clr_reg;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  wpos_reg, wpos_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] held_reg [3];
    logic [31:0] held_next [3];
    logic [63:0] last_clock_reg, last_clock_next;
    logic [31:0] stat_reg [lmed_pkg::STAT_NUM];
    logic [lmed_pkg::STAT_NUM-1:0] stat_inc;
    logic        stopped_reg, stopped_next;

    // stage 1 decode
    logic [1:0]  op;
    logic [31:0] w;
    logic [9:0]  idx;
    logic [63:0] ps;
    logic [15:0] ev_id, ev_st, ev_en, ev_len, ev_skip;
    logic        ev_ooo, ev_oor, ev_trace, marker, zero_group;
    logic        hist_idx_ok;
    logic        has_res, rd_hist, inc_hist;
    logic        use_id_addr;
    logic [16:0] raddr_ext;
    logic [HIST_AW-1:0] hist_raddr;
    lmed_pkg::result_t res1;

    assign op  = s1_item_reg.op;
    assign w   = s1_item_reg.word;
    assign idx = s1_item_reg.index;

    assign ps         = {held_reg[1], held_reg[0]};
    assign ev_id      = held_reg[2][15:0];
    assign ev_st      = held_reg[2][31:16];
    assign ev_en      = w[15:0];
    assign ev_len     = w[31:16];
    assign ev_ooo     = ps < last_clock_reg;
    assign ev_oor     = int'(ev_id) >= HIST_BINS;
    assign ev_trace   = (|(ev_st & lmed_pkg::ST_TRACE)) || (ev_len != 16'd0);
    assign hist_idx_ok = int'(idx) < HIST_BINS;
    assign marker     = (held_reg[0] == lmed_pkg::MARK_S) && (held_reg[1] == lmed_pkg::MARK_P)
                     && (held_reg[2] == lmed_pkg::MARK_I) && (w == lmed_pkg::MARK_L);
    assign zero_group = (held_reg[0] == 32'd0) && (held_reg[1] == 32'd0)
                     && (held_reg[2] == 32'd0) && (w == 32'd0);

    always_comb
    begin
        ev_skip = 16'd0;
        if (|(ev_st & lmed_pkg::ST_SUM))
        begin
            ev_skip = ev_skip + lmed_pkg::SUM_WORDS;
        end
        if (|(ev_st & lmed_pkg::ST_QDC))
        begin
            ev_skip = ev_skip + lmed_pkg::QDC_WORDS;
        end
        if (ev_trace)
        begin
            ev_skip = ev_skip + {1'b0, ev_len[15:1]};
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        wpos_next       = wpos_reg;
        skip_next       = skip_reg;
        last_clock_next = last_clock_reg;
        stopped_next    = stopped_reg;
        for (int k = 0; k < 3; k++)
        begin
            held_next[k] = held_reg[k];
        end
        stat_inc    = '0;
        res1        = '0;
        has_res     = 1'b0;
        rd_hist     = 1'b0;
        inc_hist    = 1'b0;
        use_id_addr = 1'b0;

        case (op)
            lmed_pkg::OP_HIST:
            begin
                has_res   = 1'b1;
                res1.kind = lmed_pkg::KIND_READ;
                rd_hist   = hist_idx_ok;
            end
            lmed_pkg::OP_STAT:
            begin
                has_res   = 1'b1;
                res1.kind = lmed_pkg::KIND_READ;
                if (idx < 10'(lmed_pkg::STAT_NUM))
                begin
                    res1.value = stat_reg[idx[2:0]];
                end
            end
            lmed_pkg::OP_DATA:
            begin
                if (!stopped_reg)
                begin
                    if (phase_reg == PH_SKIP)
                    begin
                        skip_next = skip_reg - 32'd1;
                        wpos_next = 2'd0;
                        if (skip_reg == 32'd1)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    else if (wpos_reg != 2'd3)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (wpos_reg == 2'(k))
                            begin
                                held_next[k] = w;
                            end
                        end
                        wpos_next = wpos_reg + 2'd1;
                    end
                    else if (phase_reg == PH_HEADER && marker)
                    begin
                        phase_next = PH_SPILL;
                        wpos_next  = 2'd0;
                    end
                    else if (phase_reg == PH_HEADER)
                    begin
                        // event header complete
                        has_res              = 1'b1;
                        use_id_addr          = 1'b1;
                        inc_hist             = !ev_oor;
                        res1.kind            = lmed_pkg::KIND_EVENT;
                        res1.timestamp       = ps;
                        res1.channel_id      = ev_id;
                        res1.event_status    = ev_st;
                        res1.energy          = ev_en;
                        res1.trace_length    = ev_len;
                        res1.out_of_order    = ev_ooo;
                        res1.id_out_of_range = ev_oor;
                        stat_inc[lmed_pkg::STAT_TRACE]  = ev_trace;
                        stat_inc[lmed_pkg::STAT_OOR]    = ev_oor;
                        stat_inc[lmed_pkg::STAT_OOO]    = ev_ooo;
                        stat_inc[lmed_pkg::STAT_PILEUP] = |(ev_st & lmed_pkg::ST_PILEUP);
                        stat_inc[lmed_pkg::STAT_SAT]    = |(ev_st & lmed_pkg::ST_SAT);
                        stat_inc[lmed_pkg::STAT_VIRT]   = |(ev_st & lmed_pkg::ST_VIRT);
                        last_clock_next = ps;
                        skip_next       = {16'd0, ev_skip};
                        phase_next      = (ev_skip != 16'd0) ? PH_SKIP : PH_HEADER;
                        wpos_next       = 2'd0;
                        if (zero_group)
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // fourth spill word: user length
                        has_res           = 1'b1;
                        res1.kind         = lmed_pkg::KIND_SPILL;
                        res1.spill_number = held_reg[0];
                        res1.wall_clock   = held_reg[2];
                        stat_inc[lmed_pkg::STAT_SPILL] = 1'b1;
                        skip_next  = (w != 32'd0) ? ((w - 32'd1) >> 1) : 32'd0;
                        phase_next = (skip_next != 32'd0) ? PH_SKIP : PH_HEADER;
                        wpos_next  = 2'd0;
                        if (zero_group)
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    assign raddr_ext  = use_id_addr ? {1'b0, ev_id} : {7'd0, idx};
    assign hist_raddr = raddr_ext[HIST_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            wpos_reg       <= 2'd0;
            skip_reg       <= 32'd0;
            last_clock_reg <= 64'd0;
            stopped_reg    <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                held_reg[k] <= 32'd0;
            end
            for (int k = 0; k < lmed_pkg::STAT_NUM; k++)
            begin
                stat_reg[k] <= 32'd0;
            end
        end
        else if (s1_go)
        begin
            phase_reg      <= phase_next;
            wpos_reg       <= wpos_next;
            skip_reg       <= skip_next;
            last_clock_reg <= last_clock_next;
            stopped_reg    <= stopped_next;
            for (int k = 0; k < 3; k++)
            begin
                held_reg[k] <= held_next[k];
            end
            for (int k = 0; k < lmed_pkg::STAT_NUM; k++)
            begin
                if (stat_inc[k])
                begin
                    stat_reg[k] <= lmed_pkg::sat_inc(stat_reg[k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Histogram memory: read on stage 1 exit, bump in stage 2.
    // A write from stage 2 in the cycle stage 1 reads the same bin is
    // forwarded instead of the stale memory word.
    // ------------------------------------------------------------------
    logic [31:0] hist_mem [HIST_BINS];
    logic [31:0] hist_q_reg;
    logic [31:0] hist_val, hist_wdata, s2_wdata;
    logic [HIST_AW-1:0] hist_waddr;
    logic        hist_we, s2_we;

    assign hist_val   = s2_fwd_reg ? s2_fwd_data_reg : hist_q_reg;
    assign s2_wdata   = lmed_pkg::sat_inc(hist_val);
    assign s2_we      = s2_valid_reg && s2_inc_reg && s2_adv;
    assign hist_we    = clr_reg || s2_we;
    assign hist_waddr = clr_reg ? clr_cnt_reg : s2_addr_reg;
    assign hist_wdata = clr_reg ? 32'd0 : s2_wdata;

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            hist_q_reg <= hist_mem[hist_raddr];
        end
    end

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == HIST_AW'(HIST_BINS - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    lmed_pkg::result_t res2;

    always_comb
    begin
        res2 = s2_res_reg;
        if (s2_hist_rd_reg)
        begin
            res2.value = hist_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= item_valid && !clr_reg;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_go && has_res;
            end
            if (out_adv)
            begin
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
        if (s1_go)
        begin
            s2_res_reg      <= res1;
            s2_hist_rd_reg  <= rd_hist;
            s2_inc_reg      <= inc_hist;
            s2_addr_reg     <= hist_raddr;
            s2_fwd_reg      <= s2_we && (s2_addr_reg == hist_raddr);
            s2_fwd_data_reg <= s2_wdata;
        end
        if (out_adv && s2_valid_reg)
        begin
            result_reg <= res2;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LMED_ASSERT(a_no_accept_clearing, clr_reg, !item_ready, "request taken during clear")
    `LMED_ASSERT_NEXT(a_stop_sticky, stopped_reg, stopped_reg, "stopped flag dropped")
    `LMED_ASSERT(a_skip_state, phase_reg == PH_SKIP,
        (skip_reg != 32'd0) && (wpos_reg == 2'd0), "skip phase with empty count")
    `LMED_ASSERT(a_inc_event_only, s2_valid_reg && s2_inc_reg,
        (s2_res_reg.kind == lmed_pkg::KIND_EVENT) && !s2_res_reg.id_out_of_range,
        "histogram bump without valid event")

endmodule

[test/lmed_record_check.sv]
// Watches the request and result channels of the list-mode event deframer,
// predicts every record and read answer, and compares them field by field.
// Depends on lmed_pkg.
module lmed_record_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  lmed_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  lmed_pkg::result_t result,
    output int                errors,
    output int                pending
);
    import lmed_pkg::*;

    localparam int BINS = HIST_BINS_DEF;

    typedef enum logic [1:0] {SEEK_HEADER, IN_SPILL, SKIPPING} parse_phase_t;

    parse_phase_t parse_phase;
    logic [1:0]   word_pos;
    logic [31:0]  skip_left;
    logic [31:0]  held [3];
    logic [63:0]  prev_clock;
    logic [31:0]  stat_cnt [STAT_NUM];
    logic [31:0]  bin_cnt [BINS];
    logic         halted;
    result_t      due_records [$];
    int           n_bad = 0;

    function automatic logic [31:0] bumped(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t check: %s got %0h want %0h", $time, what, got, want);
        n_bad++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Advance the parser by one accepted request; queue the record it causes.
    task automatic take_request(input item_t rq);
        result_t     r;
        logic [31:0] w;
        logic [31:0] skip;
        logic [63:0] ps;
        logic [15:0] id, st, en, len;
        logic        ooo;
        r = '0;
        w = rq.word;
        case (rq.op)
            OP_HIST:
            begin
                r.kind  = KIND_READ;
                r.value = (rq.index < BINS) ? bin_cnt[rq.index] : 32'd0;
                due_records.push_back(r);
            end
            OP_STAT:
            begin
                r.kind  = KIND_READ;
                r.value = (rq.index < STAT_NUM) ? stat_cnt[rq.index[2:0]] : 32'd0;
                due_records.push_back(r);
            end
            OP_DATA:
            begin
                if (halted)
                begin
                    // parsing stopped for good; word dropped
                end
                else if (parse_phase == SKIPPING)
                begin
                    if (skip_left != 0)
                        skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                        parse_phase = SEEK_HEADER;
                    word_pos = 2'd0;
                end
                else if (word_pos < 3)
                begin
                    held[word_pos] = w;
                    word_pos = word_pos + 2'd1;
                end
                else if (parse_phase == SEEK_HEADER)
                begin
                    if (held[0] == MARK_S && held[1] == MARK_P && held[2] == MARK_I &&
                        w == MARK_L)
                    begin
                        parse_phase = IN_SPILL;
                        word_pos = 2'd0;
                    end
                    else
                    begin
                        ps  = {held[1], held[0]};
                        id  = held[2][15:0];
                        st  = held[2][31:16];
                        en  = w[15:0];
                        len = w[31:16];
                        ooo = ps < prev_clock;
                        skip = 32'd0;
                        if ((st & ST_SUM) != 0)
                            skip = skip + SUM_WORDS;
                        if ((st & ST_QDC) != 0)
                            skip = skip + QDC_WORDS;
                        if ((st & ST_TRACE) != 0 || len != 0)
                        begin
                            stat_cnt[STAT_TRACE] = bumped(stat_cnt[STAT_TRACE]);
                            skip = skip + (len >> 1);
                        end
                        if (id < BINS)
                            bin_cnt[id] = bumped(bin_cnt[id]);
                        else
                            stat_cnt[STAT_OOR] = bumped(stat_cnt[STAT_OOR]);
                        if (ooo)
                            stat_cnt[STAT_OOO] = bumped(stat_cnt[STAT_OOO]);
                        prev_clock = ps;
                        if ((st & ST_PILEUP) != 0)
                            stat_cnt[STAT_PILEUP] = bumped(stat_cnt[STAT_PILEUP]);
                        if ((st & ST_SAT) != 0)
                            stat_cnt[STAT_SAT] = bumped(stat_cnt[STAT_SAT]);
                        if ((st & ST_VIRT) != 0)
                            stat_cnt[STAT_VIRT] = bumped(stat_cnt[STAT_VIRT]);
                        skip_left   = skip;
                        word_pos    = 2'd0;
                        parse_phase = (skip != 0) ? SKIPPING : SEEK_HEADER;
                        if (held[0] == 0 && held[1] == 0 && held[2] == 0 && w == 0)
                            halted = 1'b1;
                        r.kind            = KIND_EVENT;
                        r.timestamp       = ps;
                        r.channel_id      = id;
                        r.event_status    = st;
                        r.energy          = en;
                        r.trace_length    = len;
                        r.out_of_order    = ooo;
                        r.id_out_of_range = (id >= BINS);
                        due_records.push_back(r);
                    end
                end
                else
                begin
                    // fourth spill word is the user length
                    stat_cnt[STAT_SPILL] = bumped(stat_cnt[STAT_SPILL]);
                    skip_left   = (w != 0) ? ((w - 32'd1) >> 1) : 32'd0;
                    word_pos    = 2'd0;
                    parse_phase = (skip_left != 0) ? SKIPPING : SEEK_HEADER;
                    if (held[0] == 0 && held[1] == 0 && held[2] == 0 && w == 0)
                        halted = 1'b1;
                    r.kind         = KIND_SPILL;
                    r.spill_number = held[0];
                    r.wall_clock   = held[2];
                    due_records.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_record(input result_t got);
        result_t want;
        if (due_records.size() == 0)
        begin
            report_mismatch("result with nothing due, kind", 64'(got.kind), 64'd0);
        end
        else
        begin
            want = due_records.pop_front();
            check_field("kind", got.kind, want.kind);
            check_field("timestamp", got.timestamp, want.timestamp);
            check_field("channel_id", got.channel_id, want.channel_id);
            check_field("event_status", got.event_status, want.event_status);
            check_field("energy", got.energy, want.energy);
            check_field("trace_length", got.trace_length, want.trace_length);
            check_field("spill_number", got.spill_number, want.spill_number);
            check_field("wall_clock", got.wall_clock, want.wall_clock);
            check_field("out_of_order", got.out_of_order, want.out_of_order);
            check_field("id_out_of_range", got.id_out_of_range, want.id_out_of_range);
            check_field("value", got.value, want.value);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = SEEK_HEADER;
            word_pos    = 2'd0;
            skip_left   = 32'd0;
            prev_clock  = 64'd0;
            halted      = 1'b0;
            for (int i = 0; i < 3; i++)
                held[i] = 32'd0;
            for (int i = 0; i < STAT_NUM; i++)
                stat_cnt[i] = 32'd0;
            for (int i = 0; i < BINS; i++)
                bin_cnt[i] = 32'd0;
            due_records.delete();
            errors  <= n_bad;
            pending <= 0;
        end
        else
        begin
            // request first: a result can never belong to a request of the same edge
            if (item_valid && item_ready)
                take_request(item);
            if (result_valid && result_ready)
                check_record(result);
            errors  <= n_bad;
            pending <= due_records.size();
        end
    end

endmodule

[test/tb.sv]
// Top of the list-mode event deframer testbench: clock, reset, request stimulus,
// receiver stalls, watchdog and verdict. Depends on lmed_pkg, the deframer RTL
// and lmed_record_check.
module tb;
    import lmed_pkg::*;

    // op code 3 has no meaning in the block; it must be dropped silently
    localparam logic [1:0] OP_NONE = 2'd3;

    // Longest quiet stretch allowed: the histogram clearing pass after reset
    // (one bin a cycle), the long receiver hold-off and the worst random gaps
    // all fit well below this.
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 235;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    int          errors;
    int          pending;
    int          n_sent = 0;          // requests that count toward the item budget
    int          send_gap_pct = 0;    // chance of an idle cycle before a request
    int          recv_stall_pct = 0;  // chance of result_ready low in a cycle
    int          chatter_pct = 0;     // chance of a read slipped in before a data word
    logic        hold_req = 1'b0;     // asks the receiver for one long hold-off
    logic        hold_done;
    logic [63:0] stamp = 64'd0;       // running event clock for well-ordered events
    int          idle_run;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    list_mode_event_deframer_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    lmed_record_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    // Receiver: random stalls each cycle, plus one long hold-off on request of
    // the stimulus. The hold-off is counted here so the sender keeps pushing
    // requests until the block backs up and drops item_ready.
    initial
    begin
        hold_done = 1'b0;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin
        idle_run = 0;
        while (idle_run < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("tb: errors");
        $finish;
    end

    // One request. Called at a rising edge; returns at the edge that accepts it.
    // Valid stays high across back-to-back requests with no gap in between.
    task automatic put(input logic [1:0] op, input logic [31:0] w, input logic [9:0] idx);
        item_t rq;
        rq.op    = op;
        rq.word  = w;
        rq.index = idx;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_gap_pct)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= rq;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (op != OP_NONE)
            n_sent++;
    endtask

    // Histogram reads mostly hit the low ids that events use; some go anywhere.
    // Counter reads mostly name a real counter, some a bad index.
    task automatic rand_read();
        if ($urandom_range(0, 1))
            put(OP_HIST, $urandom,
                10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 31)));
        else
            put(OP_STAT, $urandom,
                10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 6)));
    endtask

    // One stream word; reads may be slipped in anywhere, they do not disturb parsing.
    task automatic data(input logic [31:0] w);
        if (chatter_pct != 0 && $urandom_range(0, 99) < chatter_pct)
            rand_read();
        put(OP_DATA, w, 10'($urandom));
    endtask

    // Event header plus the sum, QDC and trace words its status and length call for.
    task automatic send_event(input logic [63:0] ps, input logic [15:0] id,
                              input logic [15:0] st, input logic [15:0] en,
                              input logic [15:0] len);
        int n_skip;
        // never let a header spell the spill marker by accident
        if (ps == {MARK_P, MARK_S} && {st, id} == MARK_I && {len, en} == MARK_L)
            en = en ^ 16'd1;
        n_skip = 0;
        if ((st & ST_SUM) != 0)
            n_skip += SUM_WORDS;
        if ((st & ST_QDC) != 0)
            n_skip += QDC_WORDS;
        if ((st & ST_TRACE) != 0 || len != 0)
            n_skip += len >> 1;
        data(ps[31:0]);
        data(ps[63:32]);
        data({st, id});
        data({len, en});
        repeat (n_skip) data($urandom);
    endtask

    // Spill marker, the four spill words and the user words after them.
    task automatic send_spill(input logic [31:0] num, input logic [31:0] len_w,
                              input logic [31:0] clock, input logic [31:0] ulen);
        data(MARK_S);
        data(MARK_P);
        data(MARK_I);
        data(MARK_L);
        data(num);
        data(len_w);
        data(clock);
        data(ulen);
        if (ulen != 0)
            repeat ((ulen - 32'd1) >> 1) data($urandom);
    endtask

    task automatic rand_event();
        logic [63:0] ps;
        logic [15:0] id, st, en, len;
        case ($urandom_range(0, 9))
            0:       ps = {$urandom, $urandom};
            1:       ps = stamp - 64'($urandom_range(1, 1000));   // goes backwards
            default: ps = stamp + 64'($urandom_range(0, 5000));
        endcase
        stamp = ps;
        case ($urandom_range(0, 19))
            0:       id = 16'($urandom);                          // often out of range
            1:       id = 16'($urandom_range(1020, 1027));        // around the last bin
            default: id = 16'($urandom_range(0, 31));
        endcase
        // half the time keep sum and QDC words out to hold records short
        st = $urandom_range(0, 1) ? 16'($urandom) : (16'($urandom) & ~16'h000E);
        en = 16'($urandom);
        case ($urandom_range(0, 199))
            0:                  len = 16'($urandom_range(0, 255));
            1, 2, 3, 4, 5, 6,
            7, 8, 9, 10:        len = 16'($urandom_range(1, 40));
            default:            len = ($urandom_range(0, 3) == 0) ?
                                      16'($urandom_range(1, 12)) : 16'd0;
        endcase
        // a group of four zero words would stop parsing; that is kept for the end
        if (ps == 0 && id == 0 && st == 0 && en == 0 && len == 0)
            id = 16'd1;
        send_event(ps, id, st, en, len);
    endtask

    task automatic rand_record();
        int          pick;
        logic [31:0] num, clock;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            rand_event();
        else if (pick < 72)
        begin
            num   = $urandom;
            clock = $urandom;
            if (num == 0 && clock == 0)
                num = 32'd1;
            send_spill(num, $urandom, clock, $urandom_range(0, 30));
        end
        else if (pick < 84)
            repeat ($urandom_range(1, 4)) rand_read();
        else if (pick < 88)
            put(OP_NONE, $urandom, 10'($urandom));
        else if (pick < 93)
            // marker cut short on the last word: parsed as an event
            send_event({MARK_P, MARK_S}, MARK_I[15:0], MARK_I[31:16], 16'($urandom),
                       16'($urandom_range(0, 3)));
        else if (pick < 97)
            // marker cut short earlier
            send_event({MARK_P, MARK_S}, 16'($urandom), 16'($urandom) & ~16'h002E,
                       16'($urandom), 16'($urandom_range(0, 6)));
        else
            // marker whose spill words are another marker
            send_spill(MARK_S, MARK_P, MARK_I, MARK_L);
    endtask

    initial
    begin
        item_valid <= 1'b0;
        item       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: read extremes and bad indexes, the unused op, field extremes,
        // out-of-range id, out-of-order clock, trace flag with no length, empty spill
        put(OP_HIST, 32'hFFFF_FFFF, 10'd1023);
        put(OP_STAT, 32'd0, 10'(STAT_SPILL));
        put(OP_STAT, 32'd0, 10'd1023);
        put(OP_NONE, 32'hFFFF_FFFF, 10'd1023);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 16'd1023, 16'hFFFF, 16'hFFFF, 16'd1);
        send_event(64'd0, 16'hFFFF, ST_TRACE, 16'd0, 16'd0);
        send_spill(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_spill(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
        put(OP_HIST, 32'd0, 10'd1023);

        // random part in four idling phases; the first starts with a long
        // receiver hold-off and a burst of reads so the block backs up
        chatter_pct = 6;
        for (int ph = 0; ph < 4; ph++)
        begin
            int target;
            case (ph)
                0:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct <= 0;
                    hold_req <= 1'b1;
                    repeat (40) rand_read();
                end
                1:
                begin
                    send_gap_pct = 80;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct <= 80;
                end
                default:
                begin
                    send_gap_pct = 13;
                    recv_stall_pct <= 13;
                end
            endcase
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target)
                rand_record();
        end

        // stop parsing with a zero header group or an all-zero spill, show that
        // data words are then dropped, and read everything back
        chatter_pct = 0;
        if ($urandom_range(0, 1))
            send_event(64'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        else
            send_spill(32'd0, 32'd0, 32'd0, 32'd0);
        repeat (6) data($urandom);
        send_event({$urandom, $urandom}, 16'd2, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < STAT_NUM; k++)
            put(OP_STAT, $urandom, 10'(k));
        put(OP_HIST, $urandom, 10'd0);
        put(OP_HIST, $urandom, 10'd2);

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/lmed_pkg.sv
sv/list_mode_event_deframer_top.sv
test/lmed_record_check.sv
test/tb.sv
